[src/sgb_pkg.sv]
// Shared constants, types and arithmetic helpers of the separable Gaussian blur.
`timescale 1ns / 1ps
package sgb_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MAX_RADIUS = 16;

   // Ring holds every pixel from the oldest to the newest tap of one output.
   localparam int RING_DEPTH = 2 * MAX_RADIUS * (MAX_WIDTH + 1) + 1;
   localparam int RING_AW    = $clog2(RING_DEPTH);

   localparam int DIM_W      = 11;
   localparam int RAD_W      = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int FUNC_W     = 2;
   localparam int COEF_IDX_W = 5;
   localparam int COEF_W     = 16;
   localparam int PIX_W      = 16;

   localparam int X_W     = $clog2(MAX_WIDTH);
   localparam int Y_W     = $clog2(MAX_HEIGHT);
   localparam int POS_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int IDX_W   = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int COEF_AW = $clog2(MAX_RADIUS + 1);
   localparam int TAP_W   = COEF_AW + 1;
   localparam int PROD_W  = PIX_W + COEF_W + 1;
   localparam int ACC_W   = 40;

   localparam int FRAC_BITS = 15;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC_BITS - 1));
   localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] SAT_LO     = -ACC_W'(32768);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_SAMPLE = 2'd1,
      FUNC_DRAIN  = 2'd2
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH   = 2'd0,
      CSR_FRAME_HEIGHT  = 2'd1,
      CSR_KERNEL_RADIUS = 2'd2
   } csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_START,
      ST_ROW_BASE,
      ST_ISSUE,
      ST_FLUSH,
      ST_ROW_SAT,
      ST_ROW_MUL,
      ST_ROW_ACC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic decode;
      logic start;
      logic row_base;
      logic issue;
      logic row_sat;
      logic row_mul;
      logic row_acc;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic pipe_busy;
      logic kx_last;
      logic ky_last;
      logic out_free;
   } status_type;

   // Round a Q.15 accumulator to nearest with ties up, then saturate to 16 bits.
   function automatic logic signed [PIX_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] t;
      logic signed [ACC_W-1:0] q;
      t = acc + ROUND_HALF;
      q = t >>> FRAC_BITS;
      if (q > SAT_HI) begin
         return SAT_HI[PIX_W-1:0];
      end else if (q < SAT_LO) begin
         return SAT_LO[PIX_W-1:0];
      end
      return q[PIX_W-1:0];
   endfunction

endpackage

[src/sgb_req_if.sv]
// Request channel: valid, ready and the input item fields.
`timescale 1ns / 1ps
interface sgb_req_if
   import sgb_pkg::*;
;
   logic                     valid;
   logic                     ready;
   logic [FUNC_W-1:0]        func;
   logic [COEF_IDX_W-1:0]    coef_index;
   logic [COEF_W-1:0]        coef_value;
   logic signed [PIX_W-1:0]  sample;

   modport source (output valid, func, coef_index, coef_value, sample, input ready);
   modport sink (input valid, func, coef_index, coef_value, sample, output ready);
endinterface

[src/sgb_rsp_if.sv]
// Response channel: valid, ready and the result item fields.
`timescale 1ns / 1ps
interface sgb_rsp_if
   import sgb_pkg::*;
;
   logic                     valid;
   logic                     ready;
   logic signed [PIX_W-1:0]  blurred;
   logic                     last;

   modport source (output valid, blurred, last, input ready);
   modport sink (input valid, blurred, last, output ready);
endinterface

[src/sgb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sgb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[src/sgb_ctrl.sv]
// Controller state machine that sequences item decode and the tap loops.
`timescale 1ns / 1ps
module sgb_ctrl
   import sgb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output cmd_type    cmd,
   input  status_type status
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = status.emit ? ST_START : ST_IDLE;
         end
         ST_START: begin
            cmd.start = 1'b1;
            state_in  = ST_ROW_BASE;
         end
         ST_ROW_BASE: begin
            cmd.row_base = 1'b1;
            state_in     = ST_ISSUE;
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            if (status.kx_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!status.pipe_busy) begin
               state_in = ST_ROW_SAT;
            end
         end
         ST_ROW_SAT: begin
            cmd.row_sat = 1'b1;
            state_in    = ST_ROW_MUL;
         end
         ST_ROW_MUL: begin
            cmd.row_mul = 1'b1;
            state_in    = ST_ROW_ACC;
         end
         ST_ROW_ACC: begin
            cmd.row_acc = 1'b1;
            state_in    = status.ky_last ? ST_FINISH : ST_ROW_BASE;
         end
         ST_FINISH: begin
            // The result waits here until the output register can take it.
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

[src/sgb_dpath.sv]
// Datapath: registers, positions, pixel ring, tap pipeline and accumulators.
`timescale 1ns / 1ps
module sgb_dpath
   import sgb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic [FUNC_W-1:0]       req_func,
   input  logic [COEF_IDX_W-1:0]   req_coef_index,
   input  logic [COEF_W-1:0]       req_coef_value,
   input  logic signed [PIX_W-1:0] req_sample,
   input  cmd_type                 cmd,
   output status_type              status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [PIX_W-1:0] rsp_blurred,
   output logic                    rsp_last
);
   function automatic logic [COEF_AW-1:0] tap_dist(input logic signed [TAP_W-1:0] k);
      logic signed [TAP_W-1:0] a;
      a = (k < 0) ? -k : k;
      return a[COEF_AW-1:0];
   endfunction

   // Configuration registers and derived frame values.
   logic [DIM_W-1:0] fw_ff, fh_ff;
   logic [RAD_W-1:0] kr_ff;
   logic [DIM_W-1:0] eff_w, eff_h;
   logic [RAD_W-1:0] eff_r;
   logic [X_W-1:0]   wm1;
   logic [Y_W-1:0]   hm1;
   logic [2*DIM_W-1:0]     area;
   logic [RAD_W+DIM_W-1:0] rw;
   logic [POS_W-1:0] total_ff, total_in, thr_ff, thr_in;
   logic csr_hit;

   always_comb begin
      csr_hit = csr_we && (csr_index == CSR_FRAME_WIDTH || csr_index == CSR_FRAME_HEIGHT
                           || csr_index == CSR_KERNEL_RADIUS);
      eff_w = (fw_ff == '0) ? DIM_W'(1) :
              (fw_ff > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : fw_ff;
      eff_h = (fh_ff == '0) ? DIM_W'(1) :
              (fh_ff > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : fh_ff;
      eff_r = (kr_ff == '0) ? RAD_W'(1) :
              (kr_ff > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : kr_ff;
      wm1      = X_W'(eff_w - DIM_W'(1));
      hm1      = Y_W'(eff_h - DIM_W'(1));
      area     = eff_w * eff_h;
      rw       = eff_r * eff_w;
      total_in = area[POS_W-1:0];
      thr_in   = POS_W'(rw) + POS_W'(eff_r);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= DIM_W'(MAX_WIDTH);
         fh_ff <= DIM_W'(MAX_HEIGHT);
         kr_ff <= RAD_W'(1);
      end else if (csr_we) begin
         if (csr_index == CSR_FRAME_WIDTH) begin
            fw_ff <= csr_wdata[DIM_W-1:0];
         end
         if (csr_index == CSR_FRAME_HEIGHT) begin
            fh_ff <= csr_wdata[DIM_W-1:0];
         end
         if (csr_index == CSR_KERNEL_RADIUS) begin
            kr_ff <= csr_wdata[RAD_W-1:0];
         end
      end
      total_ff <= total_in;
      thr_ff   <= thr_in;
   end

   // Latched request beat.
   logic [FUNC_W-1:0]       func_ff;
   logic [COEF_IDX_W-1:0]   cidx_ff;
   logic [COEF_W-1:0]       cval_ff;
   logic signed [PIX_W-1:0] samp_ff;
   logic [COEF_W-1:0]       coef_ff [MAX_RADIUS+1];

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff <= req_func;
         cidx_ff <= req_coef_index;
         cval_ff <= req_coef_value;
         samp_ff <= req_sample;
      end
      if (cmd.decode && func_ff == FUNC_LOAD && cidx_ff <= COEF_IDX_W'(MAX_RADIUS)) begin
         coef_ff[cidx_ff[COEF_AW-1:0]] <= cval_ff;
      end
   end

   // Frame positions and ring write pointer.
   logic [POS_W-1:0]   in_pos_ff, out_pos_ff;
   logic [RING_AW-1:0] wptr_ff, wlast_ff, wptr_next;
   logic [X_W-1:0]     ox_ff;
   logic [Y_W-1:0]     oy_ff;
   logic sample_ok, ram_we, is_last, restart, emit;

   always_comb begin
      sample_ok = in_pos_ff < total_ff;
      ram_we    = cmd.decode && func_ff == FUNC_SAMPLE && sample_ok;
      is_last   = (out_pos_ff + POS_W'(1)) == total_ff;
      restart   = csr_hit || (cmd.finish && is_last);
      wptr_next = (wptr_ff == RING_AW'(RING_DEPTH - 1)) ? '0 : wptr_ff + RING_AW'(1);
      if (func_ff == FUNC_SAMPLE) begin
         emit = sample_ok && in_pos_ff >= thr_ff && out_pos_ff < total_ff;
      end else if (func_ff == FUNC_DRAIN) begin
         emit = in_pos_ff == total_ff && out_pos_ff < total_ff;
      end else begin
         emit = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         in_pos_ff  <= '0;
         out_pos_ff <= '0;
         wptr_ff    <= '0;
         ox_ff      <= '0;
         oy_ff      <= '0;
      end else begin
         if (ram_we) begin
            in_pos_ff <= in_pos_ff + POS_W'(1);
            wptr_ff   <= wptr_next;
         end
         if (cmd.finish) begin
            out_pos_ff <= out_pos_ff + POS_W'(1);
            if (ox_ff == wm1) begin
               ox_ff <= '0;
               oy_ff <= oy_ff + Y_W'(1);
            end else begin
               ox_ff <= ox_ff + X_W'(1);
            end
         end
      end
      if (ram_we) begin
         wlast_ff <= wptr_ff;
      end
   end

   // Tap counters and clamped coordinates.
   logic signed [TAP_W-1:0] kx_ff, ky_ff, r_s;
   logic signed [Y_W+1:0]   ysum;
   logic signed [X_W+1:0]   xsum;
   logic [Y_W-1:0]          yy;
   logic [X_W-1:0]          xx;
   logic [Y_W+DIM_W-1:0]    base_prod;
   logic [IDX_W-1:0]        base_ff;

   always_comb begin
      r_s  = $signed({1'b0, eff_r});
      ysum = $signed({2'b00, oy_ff}) + (Y_W+2)'(ky_ff);
      xsum = $signed({2'b00, ox_ff}) + (X_W+2)'(kx_ff);
      if (ysum < 0) begin
         yy = '0;
      end else if (ysum > $signed({2'b00, hm1})) begin
         yy = hm1;
      end else begin
         yy = ysum[Y_W-1:0];
      end
      if (xsum < 0) begin
         xx = '0;
      end else if (xsum > $signed({2'b00, wm1})) begin
         xx = wm1;
      end else begin
         xx = xsum[X_W-1:0];
      end
      base_prod = yy * eff_w;
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         ky_ff <= -r_s;
      end else if (cmd.row_acc) begin
         ky_ff <= ky_ff + TAP_W'(1);
      end
      if (cmd.row_base) begin
         kx_ff   <= -r_s;
         base_ff <= base_prod[IDX_W-1:0];
      end else if (cmd.issue) begin
         kx_ff <= kx_ff + TAP_W'(1);
      end
   end

   // Tap pipeline: index, ring distance, ring read, product, accumulate.
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic [IDX_W-1:0]   idx1_ff;
   logic [COEF_W-1:0]  coef1_ff, coef2_ff, coef3_ff;
   logic [POS_W-1:0]   rel_full;
   logic [RING_AW-1:0] rel2_ff, raddr;
   logic [RING_AW:0]   wrap_sum;
   logic [PIX_W-1:0]   ram_q;
   logic signed [PROD_W-1:0] prod4_ff, prod4_in;
   logic signed [ACC_W-1:0]  hacc_ff, vacc_ff;
   logic signed [PIX_W-1:0]  hres_ff;
   logic [COEF_W-1:0]        vcoef_ff;
   logic signed [PROD_W-1:0] vprod_ff;

   always_comb begin
      rel_full = in_pos_ff - POS_W'(1) - POS_W'(idx1_ff);
      // Distance back from the newest pixel, folded onto the ring.
      wrap_sum = {1'b0, wlast_ff} + (RING_AW+1)'(RING_DEPTH) - {1'b0, rel2_ff};
      raddr    = (wlast_ff >= rel2_ff) ? wlast_ff - rel2_ff : wrap_sum[RING_AW-1:0];
      prod4_in = $signed(ram_q) * $signed({1'b0, coef3_ff});
   end

   sgb_ram #(
      .WIDTH (PIX_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wptr_ff),
      .wr_data (samp_ff),
      .rd_addr (raddr),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      idx1_ff  <= base_ff + IDX_W'(xx);
      coef1_ff <= coef_ff[tap_dist(kx_ff)];
      rel2_ff  <= rel_full[RING_AW-1:0];
      coef2_ff <= coef1_ff;
      coef3_ff <= coef2_ff;
      prod4_ff <= prod4_in;
      if (cmd.row_base) begin
         hacc_ff <= '0;
      end else if (v4_ff) begin
         hacc_ff <= hacc_ff + ACC_W'(prod4_ff);
      end
      if (cmd.row_sat) begin
         hres_ff  <= round_sat(hacc_ff);
         vcoef_ff <= coef_ff[tap_dist(ky_ff)];
      end
      if (cmd.row_mul) begin
         vprod_ff <= hres_ff * $signed({1'b0, vcoef_ff});
      end
      if (cmd.start) begin
         vacc_ff <= '0;
      end else if (cmd.row_acc) begin
         vacc_ff <= vacc_ff + ACC_W'(vprod_ff);
      end
   end

   // Output register.
   logic                    rsp_valid_ff;
   logic signed [PIX_W-1:0] blurred_ff;
   logic                    last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         blurred_ff <= round_sat(vacc_ff);
         last_ff    <= is_last;
      end
   end

   always_comb begin
      rsp_valid        = rsp_valid_ff;
      rsp_blurred      = blurred_ff;
      rsp_last         = last_ff;
      status.emit      = emit;
      status.pipe_busy = v1_ff || v2_ff || v3_ff || v4_ff;
      status.kx_last   = kx_ff == r_s;
      status.ky_last   = ky_ff == r_s;
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end
endmodule

[src/separable_gaussian_blur_2d.sv]
// Top level of the separable Gaussian blur: controller, datapath and channel wiring.
// Loads, ignored beats and samples that emit nothing pass only through accept and decode.
// A beat that emits an output, for radius R, has one shared multiply-accumulate walk the
// (2R+1) x (2R+1) taps, one ring read per tap, then one vertical MAC per row.
// The result sits in an output register, so the next beat is accepted while it waits.
// Synchronous reset: frame positions clear, registers return to 1024 x 1024, radius 1; no RAM clear.
`timescale 1ns / 1ps
module separable_gaussian_blur_2d
   import sgb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   sgb_req_if.sink               req_bus,
   sgb_rsp_if.source             rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req_bus.ready = req_ready;

   sgb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   sgb_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_func       (req_bus.func),
      .req_coef_index (req_bus.coef_index),
      .req_coef_value (req_bus.coef_value),
      .req_sample     (req_bus.sample),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_blurred    (rsp_bus.blurred),
      .rsp_last       (rsp_bus.last)
   );
endmodule
